// ----- design/rort_pkg.sv -----
// shared types, constants and helpers for the range offset remap table
// depends on nothing; rort_ctrl and the top level refer to it by scoped names
package rort_pkg;

	localparam int ROWS       = 128;
	localparam int VALUE_BITS = 32;
	localparam int FIELD_BITS = 32;
	localparam int ROW_BITS   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_BITS   = $clog2(ROWS + 1);

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_XLATE = 2'd2;

	typedef logic [VALUE_BITS-1:0] val_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [FIELD_BITS-1:0] dest_start;
		logic [FIELD_BITS-1:0] source_start;
		logic [FIELD_BITS-1:0] span_length;
		logic [FIELD_BITS-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] mapped_value;
		logic                  matched;
		logic                  table_full;
	} out_item_t;

	typedef struct packed {
		val_t dst;
		val_t src;
		val_t len;
	} row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} st_t;

	// fit a field to the value width; upper field bits are dropped
	function automatic val_t to_val(logic [FIELD_BITS-1:0] f);
		return VALUE_BITS'(f);
	endfunction

endpackage

// ----- design/rort_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// standalone, no package use
module rort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/rort_ctrl.sv -----
// sequencer for the remap table: clear, append and in-order scan with match logic
// depends on rort_pkg; drives the row ram that the top level instantiates
module rort_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  rort_pkg::in_item_t         req,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rort_pkg::out_item_t        res,
	output logic                       ram_we,
	output logic [rort_pkg::ROW_BITS-1:0] ram_waddr,
	output rort_pkg::row_t             ram_wdata,
	output logic [rort_pkg::ROW_BITS-1:0] ram_raddr,
	input  rort_pkg::row_t             ram_rdata
);

	rort_pkg::st_t                    state_q, state_d;
	logic [rort_pkg::CNT_BITS-1:0]    count_q;
	logic [rort_pkg::CNT_BITS-1:0]    rd_idx_q;
	logic                             rd_vld_s1;
	rort_pkg::val_t                   value_q;
	rort_pkg::out_item_t              res_q;

	logic                             accept;
	logic                             full;
	logic                             issue;
	logic [rort_pkg::VALUE_BITS:0]    diff;
	logic                             hit;
	logic                             found;
	logic                             miss_end;
	rort_pkg::val_t                   mapped;

	assign accept = req_valid && req_ready;
	assign full   = (count_q == rort_pkg::CNT_BITS'(rort_pkg::ROWS));

	// scan: one read issued per cycle, compare in the cycle after on ram output
	assign issue    = (state_q == rort_pkg::ST_SCAN) && (rd_idx_q < count_q);
	assign diff     = {1'b0, value_q} - {1'b0, ram_rdata.src};
	assign hit      = !diff[rort_pkg::VALUE_BITS]
		&& (diff[rort_pkg::VALUE_BITS-1:0] < ram_rdata.len);
	assign mapped   = diff[rort_pkg::VALUE_BITS-1:0] + ram_rdata.dst;
	assign found    = (state_q == rort_pkg::ST_SCAN) && rd_vld_s1 && hit;
	assign miss_end = (state_q == rort_pkg::ST_SCAN) && !issue && !rd_vld_s1;

	assign ram_we    = accept && (req.kind == rort_pkg::KIND_LOAD) && !full;
	assign ram_waddr = count_q[rort_pkg::ROW_BITS-1:0];
	assign ram_wdata = '{dst: rort_pkg::to_val(req.dest_start),
	                     src: rort_pkg::to_val(req.source_start),
	                     len: rort_pkg::to_val(req.span_length)};
	assign ram_raddr = rd_idx_q[rort_pkg::ROW_BITS-1:0];
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rort_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			rort_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req.kind)
						rort_pkg::KIND_XLATE: state_d = rort_pkg::ST_SCAN;
						default:              state_d = rort_pkg::ST_DONE;
					endcase
				end
			end
			rort_pkg::ST_SCAN: begin
				if (found || miss_end) begin
					state_d = rort_pkg::ST_DONE;
				end
			end
			rort_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = rort_pkg::ST_IDLE;
				end
			end
			default: state_d = rort_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue && !found;
			if (accept) begin
				rd_idx_q <= '0;
				if (req.kind == rort_pkg::KIND_CLEAR) begin
					count_q <= '0;
				end else if ((req.kind == rort_pkg::KIND_LOAD) && !full) begin
					count_q <= count_q + 1'b1;
				end
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= rort_pkg::to_val(req.value);
			res_q   <= '{mapped_value: '0, matched: 1'b0,
			           table_full: (req.kind == rort_pkg::KIND_LOAD) && full};
		end else if (found) begin
			res_q <= '{mapped_value: rort_pkg::FIELD_BITS'(mapped),
			           matched: 1'b1, table_full: 1'b0};
		end else if (miss_end) begin
			res_q <= '{mapped_value: rort_pkg::FIELD_BITS'(value_q),
			           matched: 1'b0, table_full: 1'b0};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rort_pkg::CNT_BITS'(rort_pkg::ROWS))
		else $error("row count beyond table size");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rort_pkg::ST_SCAN) |-> (rd_idx_q <= count_q))
		else $error("scan index past loaded rows");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == rort_pkg::ST_IDLE))
		else $error("row write outside idle");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.kind == rort_pkg::KIND_LOAD) && full) |=> $stable(count_q))
		else $error("refused load changed row count");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == rort_pkg::ST_DONE) && !res_ready) |=> $stable(res_q))
		else $error("pending result changed");

endmodule

// ----- design/range_offset_remap_table_top.sv -----
// top level of the range offset remap table: row ram, sequencer, output register
// depends on rort_pkg, rort_ram and rort_ctrl
//
// usage
// - request channel req_valid/req_ready/req carries one beat per item:
//   kind 0 clears the table, kind 1 appends a row (dest, source, length),
//   kind 2 translates req.value, kind 3 is ignored and answers all zeros
// - response channel rsp_valid/rsp_ready/rsp returns exactly one beat per
//   request beat, in order: mapped_value, matched, table_full
// - a load into a full table (ROWS rows) is dropped and flagged by table_full
// - a translate scans the rows in order from row 0, reading one row a cycle
//   from the row ram and comparing it in the next cycle; the first row that
//   hits gives the result
// - occupancy: one item in flight inside the sequencer; a new item is taken
//   only after the sequencer has handed on the last result
// - the output register holds a finished beat while the sequencer takes and
//   works on the next item, so a stalled receiver does not hold up the input
//   until a second result is ready
// - reset empties the table (row count to zero) and drops any pending beat;
//   row ram contents are left as they are and are never read before a load
module range_offset_remap_table_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rort_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rort_pkg::out_item_t rsp
);

	logic                          res_valid;
	logic                          res_ready;
	rort_pkg::out_item_t           res;
	logic                          ram_we;
	logic [rort_pkg::ROW_BITS-1:0] ram_waddr;
	logic [rort_pkg::ROW_BITS-1:0] ram_raddr;
	rort_pkg::row_t                ram_wdata;
	rort_pkg::row_t                ram_rdata;

	logic                          out_valid_q;
	rort_pkg::out_item_t           out_q;

	// row store: one word per row, dest/source/length side by side
	rort_ram #(
		.WIDTH ($bits(rort_pkg::row_t)),
		.DEPTH (rort_pkg::ROWS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
